>>> sv/dba_pkg.sv
// Shared constants, types and codes for the diverse beam admission block.
package dba_pkg;

   localparam int DEPTH_MAX    = 8;
   localparam int FACE_COUNT   = 16;
   localparam int BEAM_SLOTS   = 8;

   localparam int BUCKETS      = (DEPTH_MAX + 1) * FACE_COUNT;
   localparam int ENTRIES      = BUCKETS * BEAM_SLOTS;
   localparam int BUCKET_W     = $clog2(BUCKETS);
   localparam int ENTRY_W      = $clog2(ENTRIES);
   localparam int SLOT_W       = (BEAM_SLOTS > 1) ? $clog2(BEAM_SLOTS) : 1;
   localparam int FILL_W       = $clog2(BEAM_SLOTS + 1);

   localparam int DEPTH_W      = 4;
   localparam int FACE_W       = 4;
   localparam int VAL_W        = 32;
   localparam int POS_W        = 20;
   localparam int DIFF_W       = POS_W + 1;
   localparam int SQ_W         = 2 * DIFF_W;
   localparam int DIST_W       = SQ_W + 2;
   localparam int ENTRY_DATA_W = VAL_W + 3 * POS_W;

   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 16;
   localparam int COUNT_W      = 4;
   localparam int SEP_W        = 16;
   localparam int SEP2_W       = 2 * SEP_W;
   localparam int ACT_W        = 3;
   localparam int OUT_SLOT_W   = 3;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;
   localparam logic [SEP_W-1:0]   SEP_RESET   = 16'd512;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BEAM_COUNT = 4'd0,
      CSR_SEPARATION = 4'd1
   } csr_index_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_NEAR_KEEP = 3'd0,
      ACT_NEAR_REPL = 3'd1,
      ACT_APPEND    = 3'd2,
      ACT_MIN_REPL  = 3'd3,
      ACT_BELOW_MIN = 3'd4
   } action_type;

   typedef struct packed {
      logic signed [POS_W-1:0] z;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] x;
   } pos_type;

   typedef struct packed {
      logic                    valid;
      logic                    hit;
      logic [SLOT_W-1:0]       slot;
      logic signed [VAL_W-1:0] value;
   } scan_res_type;

endpackage

>>> sv/dba_if.sv
// Request and response channel interfaces.
interface dba_req_if;
   import dba_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [DEPTH_W-1:0]      depth;
   logic [FACE_W-1:0]       face;
   logic signed [VAL_W-1:0] value;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;

   modport source (output valid, depth, face, value, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, depth, face, value, pos_x, pos_y, pos_z, output ready);
endinterface

interface dba_rsp_if;
   import dba_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  admitted;
   logic [ACT_W-1:0]      action;
   logic [OUT_SLOT_W-1:0] slot;

   modport source (output valid, admitted, action, slot, input ready);
   modport sink   (input valid, admitted, action, slot, output ready);
endinterface

>>> sv/dba_ram.sv
// Generic simple dual-port RAM with registered read.
module dba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/dba_dist.sv
// Distance stage: squares per axis, then sum and compare against the squared separation.
module dba_dist (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               issue_v,
   input  logic [dba_pkg::SLOT_W-1:0]         issue_slot,
   input  logic [dba_pkg::ENTRY_DATA_W-1:0]   entry_data,
   input  dba_pkg::pos_type                   cand,
   input  logic [dba_pkg::SEP2_W-1:0]         sep2,
   output dba_pkg::scan_res_type              res
);
   import dba_pkg::*;

   logic signed [POS_W-1:0]  ex, ey, ez;
   logic signed [DIFF_W-1:0] dx, dy, dz;
   logic signed [SQ_W-1:0]   sqx_in, sqy_in, sqz_in;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff, sqz_ff;
   logic                     v_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic signed [VAL_W-1:0]  val_ff;
   logic [DIST_W-1:0]        d2;

   always_comb begin
      ex = entry_data[POS_W-1:0];
      ey = entry_data[2*POS_W-1:POS_W];
      ez = entry_data[3*POS_W-1:2*POS_W];
      dx = DIFF_W'(ex) - DIFF_W'(cand.x);
      dy = DIFF_W'(ey) - DIFF_W'(cand.y);
      dz = DIFF_W'(ez) - DIFF_W'(cand.z);
      sqx_in = dx * dx;
      sqy_in = dy * dy;
      sqz_in = dz * dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= issue_v;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= issue_slot;
      val_ff  <= entry_data[ENTRY_DATA_W-1:3*POS_W];
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      sqz_ff  <= sqz_in;
   end

   assign d2 = DIST_W'(sqx_ff) + DIST_W'(sqy_ff) + DIST_W'(sqz_ff);

   always_comb begin
      res.valid = v_ff;
      res.hit   = d2 < DIST_W'(sep2);
      res.slot  = slot_ff;
      res.value = val_ff;
   end

endmodule

>>> sv/diverse_beam_admission_core.sv
// Diverse beam admission: bucket scan, near/append/minimum decision, write-back.
// The response word is registered; a request for a bucket out of range skips the fill
// and scan states. A new request word is taken only when idle, once the previous decision
// has entered the output register; a full output register holds the decision. One entry
// read per scan cycle while entries remain to be issued.
// Reset clears all bucket fill counts at once through per-bucket valid flops.
module diverse_beam_admission_core (
   input  logic                             clock,
   input  logic                             reset,
   dba_req_if.sink                          req_chan,
   dba_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [dba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dba_pkg::CSR_DATA_W-1:0]   csr_data
);
   import dba_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FILL,
      S_SCAN,
      S_DECIDE
   } state_type;

   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      count_ff;
   logic [SEP_W-1:0]        sep_ff;
   logic [SEP2_W-1:0]       sep2_ff;
   logic [BUCKETS-1:0]      fill_valid_ff, fill_valid_in;

   logic [BUCKET_W-1:0]     bucket_ff, bucket_in, req_bucket;
   logic signed [VAL_W-1:0] cand_val_ff, cand_val_in;
   pos_type                 cand_pos_ff, cand_pos_in;
   logic                    oor_ff, oor_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [FILL_W-1:0]       iss_ff, iss_in;
   logic [FILL_W-1:0]       ret_ff, ret_in;
   logic                    issue_v_ff, issue_v_in;
   logic [SLOT_W-1:0]       issue_slot_ff;
   logic                    found_ff, found_in;
   logic [SLOT_W-1:0]       near_slot_ff, near_slot_in;
   logic signed [VAL_W-1:0] near_val_ff, near_val_in;
   logic [SLOT_W-1:0]       min_slot_ff, min_slot_in;
   logic signed [VAL_W-1:0] min_val_ff, min_val_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_adm_ff, rsp_adm_in;
   action_type              rsp_act_ff, rsp_act_in;
   logic [OUT_SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic                    fill_rd_en;
   logic [FILL_W-1:0]       fill_rd_data;
   logic                    fill_wr_en;
   logic                    ent_rd_en;
   logic [ENTRY_W-1:0]      ent_rd_addr;
   logic [ENTRY_DATA_W-1:0] ent_rd_data;
   logic                    ent_wr_en;
   logic [ENTRY_W-1:0]      ent_wr_addr;
   logic [SLOT_W-1:0]       wr_slot;
   logic [FILL_W-1:0]       limit;
   scan_res_type            scan_res;
   logic                    accept;
   logic                    out_free;

   assign accept     = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_bucket = BUCKET_W'(32'(req_chan.depth) * FACE_COUNT + 32'(req_chan.face));

   always_comb begin
      if (count_ff == '0) begin
         limit = FILL_W'(1);
      end else if (32'(count_ff) > BEAM_SLOTS) begin
         limit = FILL_W'(BEAM_SLOTS);
      end else begin
         limit = FILL_W'(count_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_valid_in = fill_valid_ff;
      bucket_in     = bucket_ff;
      cand_val_in   = cand_val_ff;
      cand_pos_in   = cand_pos_ff;
      oor_in        = oor_ff;
      fill_in       = fill_ff;
      iss_in        = iss_ff;
      ret_in        = ret_ff;
      issue_v_in    = 1'b0;
      found_in      = found_ff;
      near_slot_in  = near_slot_ff;
      near_val_in   = near_val_ff;
      min_slot_in   = min_slot_ff;
      min_val_in    = min_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_adm_in    = rsp_adm_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_slot_in   = rsp_slot_ff;
      fill_rd_en    = 1'b0;
      fill_wr_en    = 1'b0;
      ent_rd_en     = 1'b0;
      ent_rd_addr   = ENTRY_W'(32'(bucket_ff) * BEAM_SLOTS + 32'(iss_ff));
      ent_wr_en     = 1'b0;
      wr_slot       = near_slot_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               bucket_in   = req_bucket;
               cand_val_in = req_chan.value;
               cand_pos_in = '{z: req_chan.pos_z, y: req_chan.pos_y, x: req_chan.pos_x};
               oor_in      = (32'(req_chan.depth) > DEPTH_MAX) ||
                             (32'(req_chan.face) >= FACE_COUNT);
               fill_rd_en  = 1'b1;
               state_in    = oor_in ? S_DECIDE : S_FILL;
            end
         end
         S_FILL: begin
            fill_in  = fill_valid_ff[bucket_ff] ? fill_rd_data : '0;
            iss_in   = '0;
            ret_in   = '0;
            found_in = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (iss_ff < fill_ff) begin
               ent_rd_en  = 1'b1;
               issue_v_in = 1'b1;
               iss_in     = iss_ff + FILL_W'(1);
            end
            if (scan_res.valid) begin
               ret_in = ret_ff + FILL_W'(1);
               // keep the first near entry only
               if (!found_ff && scan_res.hit) begin
                  found_in     = 1'b1;
                  near_slot_in = scan_res.slot;
                  near_val_in  = scan_res.value;
               end
               if (scan_res.slot == '0 || scan_res.value < min_val_ff) begin
                  min_slot_in = scan_res.slot;
                  min_val_in  = scan_res.value;
               end
            end
            if (ret_ff == fill_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (oor_ff) begin
                  rsp_adm_in  = 1'b0;
                  rsp_act_in  = ACT_BELOW_MIN;
                  rsp_slot_in = '0;
               end else if (found_ff) begin
                  wr_slot     = near_slot_ff;
                  rsp_slot_in = OUT_SLOT_W'(near_slot_ff);
                  if (cand_val_ff > near_val_ff) begin
                     ent_wr_en  = 1'b1;
                     rsp_adm_in = 1'b1;
                     rsp_act_in = ACT_NEAR_REPL;
                  end else begin
                     rsp_adm_in = 1'b0;
                     rsp_act_in = ACT_NEAR_KEEP;
                  end
               end else if (fill_ff < limit) begin
                  wr_slot                  = SLOT_W'(fill_ff);
                  ent_wr_en                = 1'b1;
                  fill_wr_en               = 1'b1;
                  fill_valid_in[bucket_ff] = 1'b1;
                  rsp_adm_in               = 1'b1;
                  rsp_act_in               = ACT_APPEND;
                  rsp_slot_in              = OUT_SLOT_W'(fill_ff);
               end else begin
                  wr_slot     = min_slot_ff;
                  rsp_slot_in = OUT_SLOT_W'(min_slot_ff);
                  if (cand_val_ff > min_val_ff) begin
                     ent_wr_en  = 1'b1;
                     rsp_adm_in = 1'b1;
                     rsp_act_in = ACT_MIN_REPL;
                  end else begin
                     rsp_adm_in = 1'b0;
                     rsp_act_in = ACT_BELOW_MIN;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      ent_wr_addr = ENTRY_W'(32'(bucket_ff) * BEAM_SLOTS + 32'(wr_slot));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= COUNT_RESET;
         sep_ff        <= SEP_RESET;
         sep2_ff       <= SEP2_W'(SEP_RESET) * SEP2_W'(SEP_RESET);
         fill_valid_ff <= '0;
         issue_v_ff    <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_valid_ff <= fill_valid_in;
         issue_v_ff    <= issue_v_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_adm_ff    <= rsp_adm_in;
         rsp_act_ff    <= rsp_act_in;
         rsp_slot_ff   <= rsp_slot_in;
         sep2_ff       <= SEP2_W'(sep_ff) * SEP2_W'(sep_ff);
         if (csr_wr_en && csr_index == CSR_BEAM_COUNT) begin
            count_ff <= csr_data[COUNT_W-1:0];
         end
         if (csr_wr_en && csr_index == CSR_SEPARATION) begin
            sep_ff <= csr_data[SEP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      bucket_ff     <= bucket_in;
      cand_val_ff   <= cand_val_in;
      cand_pos_ff   <= cand_pos_in;
      oor_ff        <= oor_in;
      fill_ff       <= fill_in;
      iss_ff        <= iss_in;
      ret_ff        <= ret_in;
      issue_slot_ff <= SLOT_W'(iss_ff);
      near_slot_ff  <= near_slot_in;
      near_val_ff   <= near_val_in;
      min_slot_ff   <= min_slot_in;
      min_val_ff    <= min_val_in;
   end

   dba_ram #(
      .WIDTH (FILL_W),
      .DEPTH (BUCKETS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (bucket_ff),
      .wr_data (fill_ff + FILL_W'(1)),
      .rd_en   (fill_rd_en),
      .rd_addr (req_bucket),
      .rd_data (fill_rd_data)
   );

   dba_ram #(
      .WIDTH (ENTRY_DATA_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data ({cand_val_ff, cand_pos_ff.z, cand_pos_ff.y, cand_pos_ff.x}),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   dba_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .issue_v    (issue_v_ff),
      .issue_slot (issue_slot_ff),
      .entry_data (ent_rd_data),
      .cand       (cand_pos_ff),
      .sep2       (sep2_ff),
      .res        (scan_res)
   );

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.admitted = rsp_adm_ff;
   assign rsp_chan.action   = rsp_act_ff;
   assign rsp_chan.slot     = rsp_slot_ff;

endmodule
